@@ rtl/mhbd_pkg.sv @@
`timescale 1ns / 1ps
package mhbd_pkg;

  // Default store depth
  localparam int CAPACITY_DEF = 64;

  // Operation codes of a request
  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_BUILD  = 2'd1,
    K_DELETE = 2'd2,
    K_READ   = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [6:0]         count;
  } out_item_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_SET_FULL,
    OP_SET_BADIDX,
    OP_SET_NOTFOUND,
    OP_RD_IDX,
    OP_RD_CAP,
    OP_BLD_INIT,
    OP_BLD_DEC,
    OP_SD_ISSUE,
    OP_SD_LEFT,
    OP_SD_RIGHT,
    OP_SD_CMP,
    OP_SD_SWAP1,
    OP_SD_SWAP2,
    OP_SRCH_INIT,
    OP_SRCH_ISSUE,
    OP_SRCH_NEXT,
    OP_SRCH_HIT,
    OP_DEL_RDLAST,
    OP_DEL_MOVE,
    OP_SU_ISSUE,
    OP_SU_SWAP1,
    OP_SU_SWAP2
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  bad_idx;
    logic  bld_done;
    logic  sd_stop;
    logic  srch_end;
    logic  srch_hit;
    logic  last_slot;
    logic  pos_zero;
    logic  par_zero;
    logic  up_win;
    logic  up_moved;
  } dp_status_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_BLD_NEXT,
    S_SD_POS,
    S_SD_LEFT,
    S_SD_RIGHT,
    S_SD_CMP,
    S_SD_SWAP1,
    S_SD_SWAP2,
    S_SRCH_ISSUE,
    S_SRCH_CHK,
    S_DEL_RDLAST,
    S_DEL_MOVE,
    S_SU_ISSUE,
    S_SU_CHK,
    S_SU_SWAP2,
    S_DONE
  } state_t;

endpackage

@@ rtl/mhbd_dp.sv @@
`timescale 1ns / 1ps
module mhbd_dp #(
  parameter int CAPACITY = mhbd_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mhbd_pkg::in_item_t    in_item,
  input  mhbd_pkg::dp_op_t      op,
  output mhbd_pkg::dp_status_t  sts,
  output mhbd_pkg::out_item_t   out_item
);
  import mhbd_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CHW = AW + 2;

  // Request and result registers
  kind_t              kind_r;
  logic signed [31:0] val_r;
  logic [5:0]         idx_r;
  status_t            status_r;
  logic signed [31:0] rd_r;

  // Heap bookkeeping
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      i_r;
  logic [AW-1:0]      pos_r;
  logic [AW-1:0]      big_r;
  logic signed [31:0] posv_r;
  logic signed [31:0] bigv_r;
  logic               moved_r;

  // Store
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               wr_en;

  // Child and parent positions
  logic [CHW-1:0] l_c;
  logic [CHW-1:0] r_c;
  logic [CHW-1:0] n_c;
  logic [AW-1:0]  pos_m1;
  logic [AW-1:0]  par_c;
  logic           l_wins;
  logic           r_wins;
  logic [31:0]    cnt_ext;

  assign l_c    = CHW'({pos_r, 1'b1});
  assign r_c    = l_c + CHW'(1);
  assign n_c    = CHW'(cnt_r);
  assign pos_m1 = pos_r - AW'(1);
  assign par_c  = AW'(pos_m1 >> 1);
  assign l_wins = (l_c < n_c) && (rdata_r > bigv_r);
  assign r_wins = (r_c < n_c) && (rdata_r > bigv_r);
  assign cnt_ext = 32'(cnt_r);

  // Report status
  assign sts.kind      = kind_r;
  assign sts.full      = (cnt_r == CW'(CAPACITY));
  assign sts.bad_idx   = (32'(idx_r) >= cnt_ext);
  assign sts.bld_done  = (i_r == '0);
  assign sts.sd_stop   = (big_r == pos_r) && !r_wins;
  assign sts.srch_end  = (i_r == cnt_r);
  assign sts.srch_hit  = (rdata_r == val_r);
  assign sts.last_slot = (CW'(pos_r) == cnt_r);
  assign sts.pos_zero  = (pos_r == '0);
  assign sts.par_zero  = (par_c == '0);
  assign sts.up_win    = (posv_r > rdata_r);
  assign sts.up_moved  = moved_r;

  assign out_item.status     = status_r;
  assign out_item.read_value = rd_r;
  assign out_item.count      = cnt_ext[6:0];

  // Select store addresses and write data
  always_comb begin
    rd_addr = pos_r;
    wr_addr = pos_r;
    wr_data = bigv_r;
    wr_en   = 1'b0;
    unique case (op)
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = val_r;
      end
      OP_RD_IDX:     rd_addr = AW'(idx_r);
      OP_SD_ISSUE:   rd_addr = pos_r;
      OP_SD_LEFT:    rd_addr = l_c[AW-1:0];
      OP_SD_RIGHT:   rd_addr = r_c[AW-1:0];
      OP_SD_SWAP1: begin
        wr_en   = 1'b1;
        wr_data = bigv_r;
      end
      OP_SD_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = big_r;
        wr_data = posv_r;
      end
      OP_SRCH_ISSUE: rd_addr = i_r[AW-1:0];
      OP_DEL_RDLAST: rd_addr = cnt_r[AW-1:0];
      OP_DEL_MOVE, OP_SU_SWAP1: begin
        wr_en   = 1'b1;
        wr_data = rdata_r;
      end
      OP_SU_ISSUE:   rd_addr = par_c;
      OP_SU_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = par_c;
        wr_data = posv_r;
      end
      default: begin
      end
    endcase
  end

  // Store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (op == OP_APPEND) begin
      cnt_r <= cnt_r + CW'(1);
    end else if (op == OP_SRCH_HIT) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Advance working registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        kind_r   <= in_item.kind;
        val_r    <= in_item.value;
        idx_r    <= in_item.index;
        status_r <= STAT_OK;
        rd_r     <= '0;
      end
      OP_SET_FULL:     status_r <= STAT_FULL;
      OP_SET_BADIDX:   status_r <= STAT_BAD_INDEX;
      OP_SET_NOTFOUND: status_r <= STAT_NOT_FOUND;
      OP_RD_CAP:       rd_r <= rdata_r;
      OP_BLD_INIT:     i_r <= cnt_r >> 1;
      OP_BLD_DEC: begin
        i_r   <= i_r - CW'(1);
        pos_r <= AW'(i_r - CW'(1));
      end
      OP_SD_LEFT: begin
        posv_r <= rdata_r;
        bigv_r <= rdata_r;
        big_r  <= pos_r;
      end
      OP_SD_RIGHT: begin
        if (l_wins) begin
          big_r  <= l_c[AW-1:0];
          bigv_r <= rdata_r;
        end
      end
      OP_SD_CMP: begin
        if (r_wins) begin
          big_r  <= r_c[AW-1:0];
          bigv_r <= rdata_r;
        end
      end
      OP_SD_SWAP2:  pos_r <= big_r;
      OP_SRCH_INIT: i_r <= '0;
      OP_SRCH_NEXT: i_r <= i_r + CW'(1);
      OP_SRCH_HIT:  pos_r <= AW'(i_r);
      OP_DEL_MOVE: begin
        posv_r  <= rdata_r;
        moved_r <= 1'b0;
      end
      OP_SU_SWAP2: begin
        pos_r   <= par_c;
        moved_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_APPEND |-> cnt_r != CW'(CAPACITY))
    else $error("append into a full store");

  a_su_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_SU_ISSUE |-> pos_r != '0)
    else $error("sift-up issued at the root");
`endif

endmodule

@@ rtl/mhbd_ctrl.sv @@
`timescale 1ns / 1ps
module mhbd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mhbd_pkg::dp_status_t  sts,
  output mhbd_pkg::dp_op_t      op,
  output logic                  busy,
  output logic                  out_valid
);
  import mhbd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.kind)
          K_APPEND: state_nxt = S_DONE;
          K_BUILD:  state_nxt = S_BLD_NEXT;
          K_DELETE: state_nxt = S_SRCH_ISSUE;
          K_READ:   state_nxt = sts.bad_idx ? S_DONE : S_RD_WAIT;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_RD_WAIT:  state_nxt = S_DONE;
      S_BLD_NEXT: state_nxt = sts.bld_done ? S_DONE : S_SD_POS;
      S_SD_POS:   state_nxt = S_SD_LEFT;
      S_SD_LEFT:  state_nxt = S_SD_RIGHT;
      S_SD_RIGHT: state_nxt = S_SD_CMP;
      S_SD_CMP: begin
        if (!sts.sd_stop) begin
          state_nxt = S_SD_SWAP1;
        end else if (sts.kind == K_BUILD) begin
          state_nxt = S_BLD_NEXT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SD_SWAP1:   state_nxt = S_SD_SWAP2;
      S_SD_SWAP2:   state_nxt = S_SD_POS;
      S_SRCH_ISSUE: state_nxt = sts.srch_end ? S_DONE : S_SRCH_CHK;
      S_SRCH_CHK:   state_nxt = sts.srch_hit ? S_DEL_RDLAST : S_SRCH_ISSUE;
      S_DEL_RDLAST: state_nxt = S_DEL_MOVE;
      S_DEL_MOVE: begin
        priority if (sts.last_slot) begin
          state_nxt = S_DONE;
        end else if (sts.pos_zero) begin
          state_nxt = S_SD_POS;
        end else begin
          state_nxt = S_SU_ISSUE;
        end
      end
      S_SU_ISSUE: state_nxt = S_SU_CHK;
      S_SU_CHK: begin
        priority if (sts.up_win) begin
          state_nxt = S_SU_SWAP2;
        end else if (sts.up_moved) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SD_POS;
        end
      end
      S_SU_SWAP2: state_nxt = sts.par_zero ? S_DONE : S_SU_ISSUE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Drive datapath commands and handshake outputs
  always_comb begin
    op        = OP_NONE;
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    unique case (state_r)
      S_IDLE: begin
        if (start) op = OP_LOAD;
      end
      S_DECODE: begin
        unique case (sts.kind)
          K_APPEND: op = sts.full ? OP_SET_FULL : OP_APPEND;
          K_BUILD:  op = OP_BLD_INIT;
          K_DELETE: op = OP_SRCH_INIT;
          K_READ:   op = sts.bad_idx ? OP_SET_BADIDX : OP_RD_IDX;
          default:  op = OP_NONE;
        endcase
      end
      S_RD_WAIT:  op = OP_RD_CAP;
      S_BLD_NEXT: op = sts.bld_done ? OP_NONE : OP_BLD_DEC;
      S_SD_POS:   op = OP_SD_ISSUE;
      S_SD_LEFT:  op = OP_SD_LEFT;
      S_SD_RIGHT: op = OP_SD_RIGHT;
      S_SD_CMP:   op = OP_SD_CMP;
      S_SD_SWAP1: op = OP_SD_SWAP1;
      S_SD_SWAP2: op = OP_SD_SWAP2;
      S_SRCH_ISSUE: op = sts.srch_end ? OP_SET_NOTFOUND : OP_SRCH_ISSUE;
      S_SRCH_CHK:   op = sts.srch_hit ? OP_SRCH_HIT : OP_SRCH_NEXT;
      S_DEL_RDLAST: op = OP_DEL_RDLAST;
      S_DEL_MOVE:   op = sts.last_slot ? OP_NONE : OP_DEL_MOVE;
      S_SU_ISSUE:   op = OP_SU_ISSUE;
      S_SU_CHK:     op = sts.up_win ? OP_SU_SWAP1 : OP_NONE;
      S_SU_SWAP2:   op = OP_SU_SWAP2;
      S_DONE:       op = OP_NONE;
      default:      op = OP_NONE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_LOAD |=> busy)
    else $error("request taken but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");
`endif

endmodule

@@ rtl/max_heap_build_and_delete.sv @@
`timescale 1ns / 1ps
// Binary max heap of signed 32-bit values in an on-chip store.
// Request channel: drive in_item and raise start; the request is taken at
// the clock edge where start is high and busy is low. Kinds: append, build
// heap, delete by value, read entry at index.
// Result channel: out_valid pulses for exactly one cycle with out_item
// (status, read value, entry count). The receiver cannot stall; the result
// must be captured in that cycle. Exactly one result per request.
// One request is in flight at a time; busy stays high until the cycle after
// the result strobe. A delete scans entries for the value, then sifts the
// moved entry up or down; a build sifts down every internal node, from the
// last one to the root. Every entry visited costs one registered read through
// the single read port of the store.
// Reset empties the heap (count zero); store contents are left as they are
// and are never used before being written.
module max_heap_build_and_delete #(
  parameter int CAPACITY = mhbd_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mhbd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output mhbd_pkg::out_item_t  out_item
);
  import mhbd_pkg::*;

  dp_op_t     op;
  dp_status_t sts;

  mhbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mhbd_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .op       (op),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule
